FILE: sv/tmhs_pkg.sv
// Shared types and constants for the timer min-heap scheduler.
// Holds opcode, result kind, status and sequencer state codes; no dependencies.
`default_nettype none

package tmhs_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int TIME_BITS_DEF = 64;
  localparam int ID_COUNT      = 32;
  localparam int ID_BITS       = 5;
  localparam int MAX_RESULTS   = 32;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_POLL = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_FIRE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_DUP        = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUP,
    S_SUP_CMP,
    S_SDN,
    S_SDN_L,
    S_SDN_R,
    S_SDN_D,
    S_DEL,
    S_DEL_RD,
    S_POLL,
    S_POLL_RD,
    S_EMIT
  } seq_state_t;

endpackage

`default_nettype wire

FILE: sv/timer_min_heap_scheduler.sv
// Timer queue as a binary min-heap with a sequencer over one heap memory port.
// Depends on tmhs_pkg (codes, state type, default parameters).
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall): one request carries an opcode (add,
//   delete, poll), a timer id, a first expiry, repeat interval and flag, and
//   the current time for poll. The block takes a request only while its
//   sequencer is idle; in_stall is high for the whole time a request is at work.
//   Output channel (out_valid / out_stall): add, delete, nop and an empty poll give
//   one result each; a poll gives one result per fired timer (up to 32),
//   with out_last_result set on the final one. Every result carries the
//   pending count and the earliest pending expiry.
//   An add climbs from the tail level by level; a delete of the tail entry
//   moves nothing, any other moves the tail into the hole, where it climbs or
//   sinks level by level; a fired repeating timer is rescheduled and sinks
//   from the root, a fired one-shot timer is deleted like the root entry.
//   The next request is taken in the cycle after the final result is loaded.
//   The result sits in an output register; a stalled receiver holds the
//   sequencer in its emit step and the result stays unchanged.
//   Reset (synchronous, rst_n low) empties the heap and clears all ids;
//   heap and position memories need no clearing, only entries below the
//   count or of active ids are ever read.
module timer_min_heap_scheduler #(
  parameter int CAPACITY  = tmhs_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = tmhs_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [4:0]  in_timer_id,
  input  wire logic [63:0] in_expire_time,
  input  wire logic [31:0] in_interval_us,
  input  wire logic        in_repeating,
  input  wire logic [63:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_status,
  output logic [4:0]       out_fired_id,
  output logic [5:0]       out_heap_count,
  output logic [63:0]      out_next_expiry,
  output logic             out_next_valid,
  output logic             out_last_result
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = PW + 2;
  localparam int TB = TIME_BITS;
  localparam int IB = tmhs_pkg::ID_BITS;

  typedef struct packed {
    logic [TB-1:0] exp;
    logic [31:0]   iv;
    logic          rep;
    logic [IB-1:0] owner;
  } entry_t;

  // heap storage and id-to-slot map
  entry_t        heap_mem [CAPACITY];
  logic [PW-1:0] slot_mem [tmhs_pkg::ID_COUNT];
  entry_t        rd_r;

  tmhs_pkg::seq_state_t state_r, state_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  entry_t         cur_r, cur_nxt;
  entry_t         child_r, child_nxt;
  logic [PW-1:0]  cidx_r, cidx_nxt;
  logic           moved_r, moved_nxt;
  logic           upfirst_r, upfirst_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [tmhs_pkg::ID_COUNT-1:0] active_r, active_nxt;
  tmhs_pkg::kind_t   kind_r, kind_nxt;
  tmhs_pkg::status_t status_r, status_nxt;
  logic [IB-1:0]  fid_r, fid_nxt;
  logic [5:0]     nfire_r, nfire_nxt;
  logic [TB-1:0]  now_r, now_nxt;
  logic [TB-1:0]  root_exp_r;

  logic           ov_r, ov_nxt;
  logic [1:0]     okind_r, okind_nxt;
  logic [1:0]     ostat_r, ostat_nxt;
  logic [4:0]     ofid_r, ofid_nxt;
  logic [5:0]     ocnt_r, ocnt_nxt;
  logic [63:0]    oexp_r, oexp_nxt;
  logic           onv_r, onv_nxt;
  logic           olast_r, olast_nxt;

  logic [PW-1:0]  rd_addr;
  logic           wr_en;
  logic [PW-1:0]  wr_addr;
  entry_t         wr_data;
  logic           sw_en;
  logic [IB-1:0]  sw_id;
  logic [PW-1:0]  sw_pos;

  logic [EW-1:0]  l_idx, r_idx, cnt_ext;
  logic [PW-1:0]  parent;
  logic [TB:0]    resched_sum;
  logic [TB-1:0]  resched;
  logic [TB-1:0]  best_exp;
  logic [7:0]     cnt8;
  logic           fire_last;
  logic           in_acc;
  logic [TB-1:0]  in_now;

  assign in_stall  = (state_r != tmhs_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_now    = in_now_time[TB-1:0];
  assign l_idx     = EW'({pos_r, 1'b1});
  assign r_idx     = l_idx + EW'(1);
  assign cnt_ext   = EW'(count_r);
  assign parent    = PW'((pos_r - PW'(1)) >> 1);
  assign cnt8      = 8'(count_r);
  assign best_exp  = moved_r ? child_r.exp : cur_r.exp;
  // saturate the reschedule at the top of the time range
  assign resched_sum = {1'b0, now_r} + (TB+1)'(rd_r.iv);
  assign resched     = resched_sum[TB] ? {TB{1'b1}} : resched_sum[TB-1:0];
  assign fire_last   = (nfire_r + 6'd1 == 6'(tmhs_pkg::MAX_RESULTS)) ||
                       (count_r == '0) || (now_r < root_exp_r);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    child_nxt   = child_r;
    cidx_nxt    = cidx_r;
    moved_nxt   = moved_r;
    upfirst_nxt = upfirst_r;
    count_nxt   = count_r;
    active_nxt  = active_r;
    kind_nxt    = kind_r;
    status_nxt  = status_r;
    fid_nxt     = fid_r;
    nfire_nxt   = nfire_r;
    now_nxt     = now_r;
    ov_nxt      = ov_r && out_stall;
    okind_nxt   = okind_r;
    ostat_nxt   = ostat_r;
    ofid_nxt    = ofid_r;
    ocnt_nxt    = ocnt_r;
    oexp_nxt    = oexp_r;
    onv_nxt     = onv_r;
    olast_nxt   = olast_r;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = cur_r;
    sw_en       = 1'b0;
    sw_id       = cur_r.owner;
    sw_pos      = pos_r;

    unique case (state_r)
      tmhs_pkg::S_IDLE: begin
        if (in_acc) begin
          status_nxt = tmhs_pkg::ST_OK;
          fid_nxt    = '0;
          state_nxt  = tmhs_pkg::S_EMIT;
          unique case (tmhs_pkg::opcode_t'(in_opcode))
            tmhs_pkg::OP_ADD: begin
              kind_nxt = tmhs_pkg::KIND_ADD;
              priority if (active_r[in_timer_id]) begin
                status_nxt = tmhs_pkg::ST_DUP;
              end else if (count_r >= CW'(CAPACITY)) begin
                status_nxt = tmhs_pkg::ST_FULL;
              end else begin
                cur_nxt.exp   = in_expire_time[TB-1:0];
                cur_nxt.iv    = in_interval_us;
                cur_nxt.rep   = in_repeating;
                cur_nxt.owner = in_timer_id;
                pos_nxt       = PW'(count_r);
                count_nxt     = count_r + CW'(1);
                active_nxt[in_timer_id] = 1'b1;
                upfirst_nxt   = 1'b0;
                state_nxt     = tmhs_pkg::S_SUP;
              end
            end
            tmhs_pkg::OP_DEL: begin
              kind_nxt = tmhs_pkg::KIND_DEL;
              if (!active_r[in_timer_id]) begin
                status_nxt = tmhs_pkg::ST_NOT_ACTIVE;
              end else begin
                active_nxt[in_timer_id] = 1'b0;
                count_nxt = count_r - CW'(1);
                pos_nxt   = slot_mem[in_timer_id];
                // the tail itself goes away: nothing moves
                if (CW'(slot_mem[in_timer_id]) != count_r - CW'(1)) begin
                  state_nxt = tmhs_pkg::S_DEL;
                end
              end
            end
            tmhs_pkg::OP_POLL: begin
              now_nxt   = in_now;
              nfire_nxt = '0;
              if (count_r == '0 || in_now < root_exp_r) begin
                kind_nxt = tmhs_pkg::KIND_NONE;
              end else begin
                kind_nxt  = tmhs_pkg::KIND_FIRE;
                state_nxt = tmhs_pkg::S_POLL;
              end
            end
            default: begin
              kind_nxt = tmhs_pkg::KIND_NONE;
            end
          endcase
        end
      end

      tmhs_pkg::S_SUP: begin
        if (pos_r == '0) begin
          if (upfirst_r) begin
            upfirst_nxt = 1'b0;
            state_nxt   = tmhs_pkg::S_SDN;
          end else begin
            wr_en     = 1'b1;
            sw_en     = 1'b1;
            state_nxt = tmhs_pkg::S_EMIT;
          end
        end else begin
          rd_addr   = parent;
          state_nxt = tmhs_pkg::S_SUP_CMP;
        end
      end

      tmhs_pkg::S_SUP_CMP: begin
        priority if (cur_r.exp < rd_r.exp) begin
          // move the parent down into the hole
          wr_en       = 1'b1;
          wr_data     = rd_r;
          sw_en       = 1'b1;
          sw_id       = rd_r.owner;
          pos_nxt     = parent;
          upfirst_nxt = 1'b0;
          state_nxt   = tmhs_pkg::S_SUP;
        end else if (upfirst_r) begin
          upfirst_nxt = 1'b0;
          state_nxt   = tmhs_pkg::S_SDN;
        end else begin
          wr_en     = 1'b1;
          sw_en     = 1'b1;
          state_nxt = tmhs_pkg::S_EMIT;
        end
      end

      tmhs_pkg::S_SDN: begin
        if (l_idx >= cnt_ext) begin
          wr_en     = 1'b1;
          sw_en     = 1'b1;
          state_nxt = tmhs_pkg::S_EMIT;
        end else begin
          rd_addr   = PW'(l_idx);
          state_nxt = tmhs_pkg::S_SDN_L;
        end
      end

      tmhs_pkg::S_SDN_L: begin
        moved_nxt = cur_r.exp > rd_r.exp;
        child_nxt = rd_r;
        cidx_nxt  = PW'(l_idx);
        if (r_idx < cnt_ext) begin
          rd_addr   = PW'(r_idx);
          state_nxt = tmhs_pkg::S_SDN_R;
        end else begin
          state_nxt = tmhs_pkg::S_SDN_D;
        end
      end

      tmhs_pkg::S_SDN_R: begin
        // left child wins a tie
        if (best_exp > rd_r.exp) begin
          moved_nxt = 1'b1;
          child_nxt = rd_r;
          cidx_nxt  = PW'(r_idx);
        end
        state_nxt = tmhs_pkg::S_SDN_D;
      end

      tmhs_pkg::S_SDN_D: begin
        wr_en = 1'b1;
        sw_en = 1'b1;
        if (moved_r) begin
          wr_data   = child_r;
          sw_id     = child_r.owner;
          pos_nxt   = cidx_r;
          state_nxt = tmhs_pkg::S_SDN;
        end else begin
          state_nxt = tmhs_pkg::S_EMIT;
        end
      end

      tmhs_pkg::S_DEL: begin
        rd_addr   = PW'(count_r);
        state_nxt = tmhs_pkg::S_DEL_RD;
      end

      tmhs_pkg::S_DEL_RD: begin
        cur_nxt     = rd_r;
        upfirst_nxt = 1'b1;
        state_nxt   = tmhs_pkg::S_SUP;
      end

      tmhs_pkg::S_POLL: begin
        rd_addr   = '0;
        state_nxt = tmhs_pkg::S_POLL_RD;
      end

      tmhs_pkg::S_POLL_RD: begin
        fid_nxt = rd_r.owner;
        pos_nxt = '0;
        if (rd_r.rep) begin
          cur_nxt     = rd_r;
          cur_nxt.exp = resched;
          upfirst_nxt = 1'b0;
          state_nxt   = tmhs_pkg::S_SDN;
        end else begin
          active_nxt[rd_r.owner] = 1'b0;
          count_nxt = count_r - CW'(1);
          state_nxt = (count_r == CW'(1)) ? tmhs_pkg::S_EMIT : tmhs_pkg::S_DEL;
        end
      end

      tmhs_pkg::S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          okind_nxt = kind_r;
          ostat_nxt = status_r;
          ofid_nxt  = fid_r;
          ocnt_nxt  = cnt8[5:0];
          oexp_nxt  = (count_r != '0) ? 64'(root_exp_r) : '0;
          onv_nxt   = count_r != '0;
          if (kind_r == tmhs_pkg::KIND_FIRE && !fire_last) begin
            olast_nxt = 1'b0;
            nfire_nxt = nfire_r + 6'd1;
            state_nxt = tmhs_pkg::S_POLL;
          end else begin
            olast_nxt = 1'b1;
            state_nxt = tmhs_pkg::S_IDLE;
          end
        end
      end

      default: state_nxt = tmhs_pkg::S_IDLE;
    endcase
  end

  // heap memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_r <= heap_mem[rd_addr];
    if (sw_en) begin
      slot_mem[sw_id] <= sw_pos;
    end
    if (wr_en && wr_addr == '0) begin
      root_exp_r <= wr_data.exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tmhs_pkg::S_IDLE;
      count_r  <= '0;
      active_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
    pos_r     <= pos_nxt;
    cur_r     <= cur_nxt;
    child_r   <= child_nxt;
    cidx_r    <= cidx_nxt;
    moved_r   <= moved_nxt;
    upfirst_r <= upfirst_nxt;
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    fid_r     <= fid_nxt;
    nfire_r   <= nfire_nxt;
    now_r     <= now_nxt;
    okind_r   <= okind_nxt;
    ostat_r   <= ostat_nxt;
    ofid_r    <= ofid_nxt;
    ocnt_r    <= ocnt_nxt;
    oexp_r    <= oexp_nxt;
    onv_r     <= onv_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_status      = ostat_r;
  assign out_fired_id    = ofid_r;
  assign out_heap_count  = ocnt_r;
  assign out_next_expiry = oexp_r;
  assign out_next_valid  = onv_r;
  assign out_last_result = olast_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("heap count above capacity");

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r) == int'(count_r))
    else $error("active ids disagree with heap count");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tmhs_pkg::KIND_FIRE |-> out_status == tmhs_pkg::ST_OK)
    else $error("fired result with error status");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc) && $past(in_opcode) != tmhs_pkg::OP_NOP |-> in_stall)
    else $error("request taken without going busy");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for timer_min_heap_scheduler: heap add, delete and poll.
// Depends on tmhs_pkg and the scheduler RTL; predicts results with its own heap.
`timescale 1ns / 100ps

module testbench;

  localparam int CAP = 32;
  localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    tmhs_pkg::kind_t   kind;
    tmhs_pkg::status_t status;
    logic [4:0]  fired_id;
    logic [5:0]  heap_count;
    logic [63:0] next_expiry;
    logic        next_valid;
    logic        last_result;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [1:0]  in_opcode = '0;
  logic [4:0]  in_timer_id = '0;
  logic [63:0] in_expire_time = '0;
  logic [31:0] in_interval_us = '0;
  logic        in_repeating = 1'b0;
  logic [63:0] in_now_time = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [1:0]  out_kind;
  wire  [1:0]  out_status;
  wire  [4:0]  out_fired_id;
  wire  [5:0]  out_heap_count;
  wire  [63:0] out_next_expiry;
  wire         out_next_valid;
  wire         out_last_result;

  timer_min_heap_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_timer_id(in_timer_id),
    .in_expire_time(in_expire_time), .in_interval_us(in_interval_us),
    .in_repeating(in_repeating), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_status(out_status), .out_fired_id(out_fired_id),
    .out_heap_count(out_heap_count), .out_next_expiry(out_next_expiry),
    .out_next_valid(out_next_valid), .out_last_result(out_last_result)
  );

  always #5 clk = ~clk;

  // Shadow heap: same layout as the block, tracked request by request.
  logic [63:0] sh_expiry [CAP];
  logic [31:0] sh_interval [CAP];
  logic        sh_repeat [CAP];
  logic [4:0]  sh_owner [CAP];
  logic [4:0]  sh_slot [32];
  logic        sh_active [32];
  int          sh_count = 0;

  timer_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  rx_hold_left = 0;
  bit  rx_random_stall = 1'b1;
  bit  tx_random_idle = 1'b1;
  bit  long_hold = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h (t=%0t)", what, got, want, $time);
    error_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [63:0] e;
    logic [31:0] iv;
    logic r;
    logic [4:0] o;
    e = sh_expiry[a]; iv = sh_interval[a]; r = sh_repeat[a]; o = sh_owner[a];
    sh_expiry[a] = sh_expiry[b]; sh_interval[a] = sh_interval[b];
    sh_repeat[a] = sh_repeat[b]; sh_owner[a] = sh_owner[b];
    sh_expiry[b] = e; sh_interval[b] = iv; sh_repeat[b] = r; sh_owner[b] = o;
    sh_slot[sh_owner[a]] = a[4:0];
    sh_slot[sh_owner[b]] = b[4:0];
  endfunction

  function automatic void sift_up(input int p);
    int parent;
    while (p > 0) begin
      parent = (p - 1) / 2;
      if (sh_expiry[p] < sh_expiry[parent]) begin
        swap_slots(p, parent);
        p = parent;
      end else break;
    end
  endfunction

  function automatic void sift_down(input int p);
    int best;
    while (p * 2 + 1 < sh_count) begin
      best = p;
      if (sh_expiry[best] > sh_expiry[p*2+1]) best = p * 2 + 1;
      if (p * 2 + 2 < sh_count && sh_expiry[best] > sh_expiry[p*2+2]) best = p * 2 + 2;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function automatic void remove_slot(input int p);
    int tail;
    tail = sh_count - 1;
    sh_active[sh_owner[p]] = 1'b0;
    if (p != tail) begin
      sh_expiry[p] = sh_expiry[tail]; sh_interval[p] = sh_interval[tail];
      sh_repeat[p] = sh_repeat[tail]; sh_owner[p] = sh_owner[tail];
      sh_slot[sh_owner[p]] = p[4:0];
    end
    sh_count = tail;
    if (p < sh_count) begin
      if (p > 0 && sh_expiry[p] < sh_expiry[(p-1)/2]) sift_up(p);
      else sift_down(p);
    end
  endfunction

  function automatic void push_result(input tmhs_pkg::kind_t k, input tmhs_pkg::status_t s,
                                      input logic [4:0] fid);
    timer_result_t r;
    r.kind = k;
    r.status = s;
    r.fired_id = fid;
    r.heap_count = sh_count[5:0];
    r.next_expiry = sh_count != 0 ? sh_expiry[0] : 64'd0;
    r.next_valid = sh_count != 0;
    r.last_result = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out every result one request causes and queue them in order.
  function automatic void predict_request(input tmhs_pkg::opcode_t op, input logic [4:0] id,
      input logic [63:0] exp_t, input logic [31:0] iv, input logic rep,
      input logic [63:0] now);
    int n;
    tmhs_pkg::status_t st;
    logic [4:0] fid;
    n = 0;
    unique case (op)
      tmhs_pkg::OP_ADD: begin
        st = tmhs_pkg::ST_OK;
        if (sh_active[id]) st = tmhs_pkg::ST_DUP;
        else if (sh_count >= CAP) st = tmhs_pkg::ST_FULL;
        else begin
          sh_expiry[sh_count] = exp_t; sh_interval[sh_count] = iv;
          sh_repeat[sh_count] = rep; sh_owner[sh_count] = id;
          sh_slot[id] = sh_count[4:0]; sh_active[id] = 1'b1;
          sh_count++;
          sift_up(sh_count - 1);
        end
        push_result(tmhs_pkg::KIND_ADD, st, '0);
      end
      tmhs_pkg::OP_DEL: begin
        st = tmhs_pkg::ST_NOT_ACTIVE;
        if (sh_active[id]) begin
          remove_slot(int'(sh_slot[id]));
          st = tmhs_pkg::ST_OK;
        end
        push_result(tmhs_pkg::KIND_DEL, st, '0);
      end
      tmhs_pkg::OP_POLL: begin
        while (n < tmhs_pkg::MAX_RESULTS && sh_count > 0 && now >= sh_expiry[0]) begin
          fid = sh_owner[0];
          if (sh_repeat[0]) begin
            sh_expiry[0] = ({32'd0, sh_interval[0]} > TMAX - now) ? TMAX
                           : now + {32'd0, sh_interval[0]};
            sift_down(0);
          end else remove_slot(0);
          push_result(tmhs_pkg::KIND_FIRE, tmhs_pkg::ST_OK, fid);
          n++;
        end
        if (n == 0) push_result(tmhs_pkg::KIND_NONE, tmhs_pkg::ST_OK, '0);
      end
      default: push_result(tmhs_pkg::KIND_NONE, tmhs_pkg::ST_OK, '0);
    endcase
    pending_results[$].last_result = 1'b1;
  endfunction

  // Drive one request and hold it until accepted; predict at acceptance.
  // Valid stays up after acceptance until the next request replaces it or release_input drops it.
  task automatic send_request(input tmhs_pkg::opcode_t op, input logic [4:0] id,
      input logic [63:0] exp_t, input logic [31:0] iv, input logic rep,
      input logic [63:0] now);
    int gap;
    if (tx_random_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_timer_id <= id;
    in_expire_time <= exp_t;
    in_interval_us <= iv;
    in_repeating <= rep;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, id, exp_t, iv, rep, now);
  endtask

  // Drop valid after the last request of a sequence.
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Receiver stall: random bursts, or one long hold-off when asked.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_random_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", 64'(out_kind), 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_kind != w.kind) report_mismatch("kind", 64'(out_kind), 64'(w.kind));
        if (out_status != w.status)
          report_mismatch("status", 64'(out_status), 64'(w.status));
        if (out_fired_id != w.fired_id)
          report_mismatch("fired_id", 64'(out_fired_id), 64'(w.fired_id));
        if (out_heap_count != w.heap_count)
          report_mismatch("heap_count", 64'(out_heap_count), 64'(w.heap_count));
        if (out_next_valid != w.next_valid)
          report_mismatch("next_valid", 64'(out_next_valid), 64'(w.next_valid));
        if (out_next_expiry != w.next_expiry)
          report_mismatch("next_expiry", out_next_expiry, w.next_expiry);
        if (out_last_result != w.last_result)
          report_mismatch("last_result", 64'(out_last_result), 64'(w.last_result));
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Directed: field extremes, every opcode and each special case.
  task automatic test_directed();
    send_request(tmhs_pkg::OP_DEL, 5'd3, 64'd0, 32'd1, 1'b0, 64'd0);   // delete inactive id
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, TMAX);   // empty poll
    send_request(tmhs_pkg::OP_NOP, 5'd31, TMAX, 32'hFFFF_FFFF, 1'b1, TMAX); // opcode three
    send_request(tmhs_pkg::OP_ADD, 5'd0, 64'd100, 32'hFFFF_FFFF, 1'b1, 64'd0);
    send_request(tmhs_pkg::OP_ADD, 5'd0, 64'd5, 32'd1, 1'b0, 64'd0);   // duplicate id
    send_request(tmhs_pkg::OP_ADD, 5'd31, TMAX, 32'd1, 1'b0, 64'd0);
    send_request(tmhs_pkg::OP_ADD, 5'd7, 64'd100, 32'd1, 1'b0, 64'd0); // equal expiry
    send_request(tmhs_pkg::OP_ADD, 5'd8, 64'd100, 32'd1, 1'b0, 64'd0);
    send_request(tmhs_pkg::OP_ADD, 5'd9, 64'd0, 32'd1, 1'b1, 64'd0);
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, 64'd50);
    send_request(tmhs_pkg::OP_DEL, 5'd7, 64'd0, 32'd1, 1'b0, 64'd0);
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, TMAX - 64'd5); // saturated
    send_request(tmhs_pkg::OP_ADD, 5'd12, 64'd10, 32'd0, 1'b1, 64'd0); // zero interval
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, 64'd20);
    send_request(tmhs_pkg::OP_DEL, 5'd12, 64'd0, 32'd1, 1'b0, 64'd0);
    for (int i = 0; i < 32; i++)
      send_request(tmhs_pkg::OP_ADD, i[4:0], rand64(), 32'd1, 1'b0, 64'd0);
    send_request(tmhs_pkg::OP_ADD, 5'd20, 64'd0, 32'd1, 1'b0, 64'd0);
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, TMAX);   // many expiries
    send_request(tmhs_pkg::OP_POLL, 5'd0, 64'd0, 32'd1, 1'b0, TMAX);
    release_input();
    drain();
  endtask

  // Long receiver hold-off while requests keep coming.
  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++)
          send_request(tmhs_pkg::OP_ADD, 5'($urandom_range(0, 31)),
                       64'($urandom_range(0, 1000)), 32'd1, 1'b0, 64'd0);
        release_input();
      end
    join
    drain();
  endtask

  // Random: mostly adds/deletes of small times, polls of rising time.
  task automatic test_random(input int count);
    logic [63:0] now;
    logic [63:0] exp_v;
    logic [63:0] now_v;
    logic [31:0] iv_v;
    int sel;
    now = 0;
    for (int i = 0; i < count; i++) begin
      if (i > count * 3 / 4) begin
        tx_random_idle = 1'b0;
        rx_random_stall = 1'b0;
      end
      sel = $urandom_range(0, 9);
      now = now + 64'($urandom_range(0, 400));
      if (sel < 5) begin
        exp_v = ($urandom_range(0, 7) == 0) ? rand64() : now + 64'($urandom_range(0, 2000));
        iv_v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1500);
        send_request(tmhs_pkg::OP_ADD, 5'($urandom_range(0, 31)), exp_v, iv_v,
                     1'($urandom_range(0, 1)), rand64());
      end else if (sel < 7) begin
        send_request(tmhs_pkg::OP_DEL, 5'($urandom_range(0, 31)), rand64(), $urandom,
                     1'($urandom_range(0, 1)), rand64());
      end else if (sel < 9) begin
        now_v = ($urandom_range(0, 15) == 0) ? rand64() : now;
        send_request(tmhs_pkg::OP_POLL, 5'($urandom_range(0, 31)), rand64(), $urandom,
                     1'($urandom_range(0, 1)), now_v);
      end else begin
        send_request(tmhs_pkg::OP_NOP, 5'($urandom_range(0, 31)), rand64(), $urandom,
                     1'b1, rand64());
      end
    end
    release_input();
    drain();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) sh_active[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(230);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

FILE: timer_min_heap_scheduler.f
sv/tmhs_pkg.sv
sv/timer_min_heap_scheduler.sv
tb/testbench.sv
